// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/mset_pkg.sv -----
// Types and constants shared by the event timer modules.
package mset_pkg;

  localparam int unsigned SlotsDefault = 32;
  // The 5-bit slot field reaches this many slots at most.
  localparam int unsigned MaxAddr = 32;

  typedef enum logic [2:0] {
    K_TICK       = 3'd0,
    K_DISPATCH   = 3'd1,
    K_SET_PERIOD = 3'd2,
    K_SET_COUNT  = 3'd3,
    K_SET_STATUS = 3'd4,
    K_SET_TYPE   = 3'd5,
    K_START      = 3'd6,
    K_READ       = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_DIS  = 2'd0,
    ST_EN   = 2'd1,
    ST_DUE  = 2'd2,
    ST_ONCE = 2'd3
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  slot;
    logic [15:0] value;
  } item_t;

  typedef struct packed {
    logic        event_valid;
    logic [4:0]  slot_index;
    status_t     slot_status;
    logic        slot_one_shot;
    logic [15:0] slot_period;
    logic [15:0] slot_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic take;
    logic apply;
    logic clr_idx;
    logic inc_idx;
    logic tick_step;
    logic release_slot;
    logic load_single;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic cur_due;
    logic more_due;
    logic idx_last;
  } stat_t;

endpackage

// ----- hw/rtl/mset_dp.sv -----
// Datapath of the event timer: slot table, scan index, held item and result register.
module mset_dp #(
  parameter int unsigned SLOTS = mset_pkg::SlotsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  mset_pkg::cmd_t   cmd,
  input  mset_pkg::item_t  item,
  input  logic             result_ready,
  output mset_pkg::stat_t  stat,
  output logic             result_valid,
  output mset_pkg::result_t result
);

  localparam int unsigned Depth = (SLOTS < mset_pkg::MaxAddr) ? SLOTS : mset_pkg::MaxAddr;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  mset_pkg::status_t status_store [Depth];
  logic              one_shot_store [Depth];
  logic [15:0]       period_store [Depth];
  logic [15:0]       count_store [Depth];

  logic [AW-1:0]     idx;
  mset_pkg::item_t   held;

  logic [AW-1:0]     rd_idx;
  logic [AW-1:0]     in_idx;
  mset_pkg::status_t cur_status;
  logic              cur_one_shot;
  logic [15:0]       cur_period;
  logic [15:0]       cur_count;
  logic [15:0]       cnt_inc;
  mset_pkg::status_t rel_status;
  logic              ok_in;
  logic              ok_held;
  logic [Depth-1:0]  due_above;
  mset_pkg::result_t result_next;

  // A held read addresses its own slot; tick and dispatch walks use the scan index.
  assign rd_idx       = (held.kind == mset_pkg::K_READ) ? held.slot[AW-1:0] : idx;
  assign in_idx       = item.slot[AW-1:0];
  assign cur_status   = status_store[rd_idx];
  assign cur_one_shot = one_shot_store[rd_idx];
  assign cur_period   = period_store[rd_idx];
  assign cur_count    = count_store[rd_idx];
  assign cnt_inc      = cur_count + 16'd1;
  assign rel_status   = cur_one_shot ? mset_pkg::ST_ONCE : mset_pkg::ST_EN;
  assign ok_in        = 32'(item.slot) < SLOTS;
  assign ok_held      = 32'(held.slot) < SLOTS;

  // Due slots strictly above the scan index decide whether this dispatch is the last one.
  always_comb begin
    for (int j = 0; j < Depth; j++) begin
      due_above[j] = (status_store[j] == mset_pkg::ST_DUE) && (AW'(j) > idx);
    end
  end

  assign stat.out_free = !result_valid || result_ready;
  assign stat.cur_due  = (cur_status == mset_pkg::ST_DUE);
  assign stat.more_due = |due_above;
  assign stat.idx_last = (idx == AW'(Depth - 1));

  always_comb begin
    result_next = '0;
    result_next.last = 1'b1;
    if (cmd.release_slot) begin
      result_next.event_valid   = 1'b1;
      result_next.slot_index    = 5'(idx);
      result_next.slot_status   = rel_status;
      result_next.slot_one_shot = cur_one_shot;
      result_next.slot_period   = cur_period;
      result_next.slot_count    = cur_count;
      result_next.last          = !stat.more_due;
    end else if (held.kind == mset_pkg::K_READ) begin
      result_next.slot_index = held.slot;
      if (ok_held) begin
        result_next.slot_status   = cur_status;
        result_next.slot_one_shot = cur_one_shot;
        result_next.slot_period   = cur_period;
        result_next.slot_count    = cur_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < Depth; j++) begin
        status_store[j]   <= mset_pkg::ST_DIS;
        one_shot_store[j] <= 1'b0;
        period_store[j]   <= '0;
        count_store[j]    <= '0;
      end
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.take) begin
        held <= item;
      end
      if (cmd.clr_idx) begin
        idx <= '0;
      end else if (cmd.inc_idx) begin
        idx <= idx + AW'(1);
      end

      if (cmd.apply && ok_in) begin
        case (item.kind)
          mset_pkg::K_SET_PERIOD: period_store[in_idx] <= item.value;
          mset_pkg::K_SET_COUNT:  count_store[in_idx] <= item.value;
          mset_pkg::K_SET_STATUS: begin
            if (item.value[15:2] == '0) begin
              status_store[in_idx] <= mset_pkg::status_t'(item.value[1:0]);
            end
          end
          mset_pkg::K_SET_TYPE: begin
            if (item.value[15:1] == '0) begin
              one_shot_store[in_idx] <= item.value[0];
            end
          end
          mset_pkg::K_START: begin
            period_store[in_idx] <= item.value;
            count_store[in_idx]  <= '0;
            status_store[in_idx] <= mset_pkg::ST_EN;
          end
          default: ;
        endcase
      end

      if (cmd.tick_step && cur_status == mset_pkg::ST_EN) begin
        if (cnt_inc == cur_period) begin
          status_store[idx] <= mset_pkg::ST_DUE;
          count_store[idx]  <= '0;
        end else begin
          count_store[idx] <= cnt_inc;
        end
      end

      if (cmd.release_slot) begin
        status_store[idx] <= rel_status;
      end

      if (cmd.release_slot || cmd.load_single) begin
        result_valid <= 1'b1;
        result       <= result_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/mset_ctrl.sv -----
// Controller of the event timer: sequences accepts, scans and result loads.
module mset_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  mset_pkg::kind_t item_kind,
  input  mset_pkg::stat_t stat,
  output logic            item_ready,
  output mset_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_DISP,
    S_SINGLE
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.take = 1'b1;
          case (item_kind)
            mset_pkg::K_TICK: begin
              cmd.clr_idx = 1'b1;
              state_next  = S_TICK;
            end
            mset_pkg::K_DISPATCH: begin
              cmd.clr_idx = 1'b1;
              state_next  = S_DISP;
            end
            mset_pkg::K_READ: state_next = S_SINGLE;
            default: cmd.apply = 1'b1;
          endcase
        end
      end
      S_TICK: begin
        cmd.tick_step = 1'b1;
        if (stat.idx_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      S_DISP: begin
        if (stat.cur_due) begin
          if (stat.out_free) begin
            cmd.release_slot = 1'b1;
            if (!stat.more_due) begin
              state_next = S_IDLE;
            end else begin
              cmd.inc_idx = 1'b1;
            end
          end
        end else if (stat.idx_last) begin
          // The scan ended without a single due slot.
          state_next = S_SINGLE;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      S_SINGLE: begin
        if (stat.out_free) begin
          cmd.load_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/multi_slot_event_timer_core.sv -----
// Top level of the multi-slot event timer.
// Usage:
// The item channel (item_valid, item_ready, item) carries commands: tick,
// dispatch, set period, set counter, set status, set type, start and read.
// The result channel (result_valid, result_ready, result) returns events and
// read data; last marks the final result of an item.
// Set and start items are applied on acceptance and leave the block ready for
// the next item. A read moves to the single-result state, which loads the
// slot's data into the result register once that register is free. A tick
// walks the whole slot table one slot per cycle and is ready again once the
// walk ends. A dispatch walks the same way, emits each due slot as it passes
// it and stops after the last due slot; when no slot is due one empty result
// with last set follows the full walk. Walks read the slot at the scan index.
// Reset clears every slot to disabled, periodic, period and counter zero,
// and empties the result register. When the receiver stalls, the held result
// stays in place and the dispatch walk pauses on the next due slot.
module multi_slot_event_timer_core #(
  parameter int unsigned SLOTS = mset_pkg::SlotsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  mset_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output mset_pkg::result_t result
);

  mset_pkg::cmd_t  cmd;
  mset_pkg::stat_t stat;

  mset_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_kind  (item.kind),
    .stat       (stat),
    .item_ready (item_ready),
    .cmd        (cmd)
  );

  mset_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .result_ready (result_ready),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ----- hw/rtl/mset_chk.sv -----
// Port-level checker for the event timer, bound to the top level.
`include "assert_macros.svh"

module mset_chk (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input mset_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_ready,
  input mset_pkg::result_t result
);

  `CHK_ASSERT(a_stall_hold, clk, rst, (result_valid && !result_ready |=> result_valid && $stable(result)), "result changed while stalled")
  `CHK_ASSERT(a_plain_is_last, clk, rst, (result_valid && !result.event_valid |-> result.last), "non-event result without last")
  `CHK_ASSERT(a_event_released, clk, rst, (result_valid && result.event_valid |-> result.slot_status == mset_pkg::ST_EN || result.slot_status == mset_pkg::ST_ONCE), "dispatched slot still due")
  `CHK_ASSERT(a_walk_busy, clk, rst, (item_valid && item_ready && (item.kind == mset_pkg::K_TICK || item.kind == mset_pkg::K_DISPATCH || item.kind == mset_pkg::K_READ) |=> !item_ready), "item accepted during a walk")
  `CHK_ASSERT_ALWAYS(a_reset_state, clk, (rst |=> item_ready && !result_valid), "block not idle after reset")

endmodule

bind multi_slot_event_timer_core mset_chk u_mset_chk (.*);
